>>> hw/rtl/hfa_pkg.sv
`timescale 1ns / 1ps
// hfa_pkg: shared types and constants of the hole fit allocator
// no dependencies

package hfa_pkg;

    localparam int COUNT_W = 5;
    localparam int CFG_DATA_W = 5;

    localparam logic [1:0] POLICY_FIRST = 2'd0;
    localparam logic [1:0] POLICY_BEST = 2'd1;
    localparam logic [1:0] POLICY_WORST = 2'd2;

    localparam logic CFG_FIT_POLICY = 1'b0;
    localparam logic CFG_HOLE_COUNT = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [3:0]  hole_index;
        logic [15:0] hole_size;
        logic [15:0] request_size;
    } item_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  chosen_index;
        logic [15:0] chosen_original_size;
        logic [15:0] remaining_after;
    } result_t;

    // candidate status traveling along the cell row
    typedef struct packed {
        logic valid;
        logic have;
    } cand_flags_t;

    // table write command broadcast to all cells
    typedef struct packed {
        logic load;
        logic update;
    } cell_ctl_t;

endpackage

>>> hw/rtl/hfa_cell.sv
`timescale 1ns / 1ps
// hfa_cell: one table entry plus one stage of the candidate chain
// depends on hfa_pkg

module hfa_cell #(
    parameter int K = 0,
    parameter int IDX_W = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  policy,
    input  logic [hfa_pkg::COUNT_W-1:0] hole_count,
    input  logic [SIZE_BITS-1:0]        req_size,
    input  hfa_pkg::cell_ctl_t          ctl,
    input  logic [IDX_W-1:0]            sel_idx,
    input  logic [SIZE_BITS-1:0]        wr_data,
    input  hfa_pkg::cand_flags_t        flags_in,
    input  logic [IDX_W-1:0]            idx_in,
    input  logic [SIZE_BITS-1:0]        orig_in,
    input  logic [SIZE_BITS-1:0]        rem_in,
    output hfa_pkg::cand_flags_t        flags_out,
    output logic [IDX_W-1:0]            idx_out,
    output logic [SIZE_BITS-1:0]        orig_out,
    output logic [SIZE_BITS-1:0]        rem_out
);
    import hfa_pkg::*;

    localparam logic [IDX_W-1:0] KI = IDX_W'(K);
    localparam logic [31:0] KU = 32'(K);

    logic [SIZE_BITS-1:0] orig_reg;
    logic [SIZE_BITS-1:0] rem_reg;
    cand_flags_t          flags_reg;
    cand_flags_t          flags_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [SIZE_BITS-1:0] corig_reg;
    logic [SIZE_BITS-1:0] corig_next;
    logic [SIZE_BITS-1:0] crem_reg;
    logic [SIZE_BITS-1:0] crem_next;

    logic in_use;
    logic fits;
    logic better;
    logic take;
    logic hit;

    assign in_use = 32'(hole_count) > KU;
    assign fits = in_use && (rem_reg >= req_size);
    assign hit = (sel_idx == KI);

    always_comb
    begin
        case (policy)
            POLICY_BEST:  better = rem_reg < rem_in;
            POLICY_WORST: better = rem_reg > rem_in;
            default:      better = 1'b0;
        endcase
        take = flags_in.valid && fits && (!flags_in.have || better);
        flags_next.valid = flags_in.valid;
        flags_next.have = flags_in.have || take;
        idx_next = take ? KI : idx_in;
        corig_next = take ? orig_reg : orig_in;
        crem_next = take ? rem_reg : rem_in;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && hit)
        begin
            orig_reg <= wr_data;
            rem_reg <= wr_data;
        end
        else if (ctl.update && hit)
        begin
            rem_reg <= wr_data;
        end
        idx_reg <= idx_next;
        corig_reg <= corig_next;
        crem_reg <= crem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags_out = flags_reg;
    assign idx_out = idx_reg;
    assign orig_out = corig_reg;
    assign rem_out = crem_reg;

endmodule

>>> hw/rtl/hole_fit_allocator.sv
`timescale 1ns / 1ps
// hole_fit_allocator: top level, controller, config registers and cell row
// depends on hfa_pkg and hfa_cell

// A load item is written into its hole cell when accepted and gives no result. A
// request item keeps busy high until its scan finishes, so no further item is
// taken while it runs. Its result is strobed on done once the candidate has
// travelled through the row of hole cells one cell per cycle, and the chosen
// hole's remaining size is written back as the result is registered. done is
// high for one cycle and cannot be held off; the receiver must take it then.
module hole_fit_allocator #(
    parameter int MAX_HOLES = 16,
    parameter int SIZE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hfa_pkg::item_t                 item,
    output logic                           done,
    output hfa_pkg::result_t               result,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [hfa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import hfa_pkg::*;

    localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic                 launch_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [1:0]           policy_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic                 done_reg;
    result_t              result_reg;

    logic                 accept;
    logic                 finish;
    logic                 load_ok;
    logic [31:0]          load_idx32;
    logic [31:0]          hole_size32;
    logic [31:0]          req_size32;
    logic [31:0]          pick_idx32;
    logic [31:0]          pick_orig32;
    logic [31:0]          new_rem32;
    logic [SIZE_BITS-1:0] new_rem;
    cell_ctl_t            ctl;
    logic [IDX_W-1:0]     sel_idx;
    logic [SIZE_BITS-1:0] wr_data;

    cand_flags_t          flags_w [MAX_HOLES+1];
    logic [IDX_W-1:0]     idx_w   [MAX_HOLES+1];
    logic [SIZE_BITS-1:0] orig_w  [MAX_HOLES+1];
    logic [SIZE_BITS-1:0] rem_w   [MAX_HOLES+1];

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign finish = (state_reg == ST_SCAN) && flags_w[MAX_HOLES].valid;

    assign load_idx32 = 32'(item.hole_index);
    assign hole_size32 = 32'(item.hole_size);
    assign req_size32 = 32'(item.request_size);
    assign load_ok = load_idx32 < 32'(MAX_HOLES);

    assign new_rem = rem_w[MAX_HOLES] - req_reg;
    assign new_rem32 = 32'(new_rem);
    assign pick_idx32 = 32'(idx_w[MAX_HOLES]);
    assign pick_orig32 = 32'(orig_w[MAX_HOLES]);

    always_comb
    begin
        ctl.load = accept && (item.mode == MODE_LOAD) && load_ok;
        ctl.update = finish && flags_w[MAX_HOLES].have;
        sel_idx = ctl.load ? load_idx32[IDX_W-1:0] : idx_w[MAX_HOLES];
        wr_data = ctl.load ? hole_size32[SIZE_BITS-1:0] : new_rem;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.mode == MODE_REQUEST))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            launch_reg <= 1'b0;
            done_reg <= 1'b0;
            policy_reg <= POLICY_FIRST;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            launch_reg <= accept && (item.mode == MODE_REQUEST);
            done_reg <= finish;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_POLICY: policy_reg <= cfg_data[1:0];
                    CFG_HOLE_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.mode == MODE_REQUEST))
        begin
            req_reg <= req_size32[SIZE_BITS-1:0];
        end
        if (finish)
        begin
            if (flags_w[MAX_HOLES].have)
            begin
                result_reg.found <= 1'b1;
                result_reg.chosen_index <= pick_idx32[3:0];
                result_reg.chosen_original_size <= pick_orig32[15:0];
                result_reg.remaining_after <= new_rem32[15:0];
            end
            else
            begin
                result_reg <= '0;
            end
        end
    end

    // chain head: a fresh empty candidate
    assign flags_w[0].valid = launch_reg;
    assign flags_w[0].have = 1'b0;
    assign idx_w[0] = '0;
    assign orig_w[0] = '0;
    assign rem_w[0] = '0;

    for (genvar k = 0; k < MAX_HOLES; k++)
    begin : g_cell
        hfa_cell #(
            .K         (k),
            .IDX_W     (IDX_W),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .policy     (policy_reg),
            .hole_count (count_reg),
            .req_size   (req_reg),
            .ctl        (ctl),
            .sel_idx    (sel_idx),
            .wr_data    (wr_data),
            .flags_in   (flags_w[k]),
            .idx_in     (idx_w[k]),
            .orig_in    (orig_w[k]),
            .rem_in     (rem_w[k]),
            .flags_out  (flags_w[k+1]),
            .idx_out    (idx_w[k+1]),
            .orig_out   (orig_w[k+1]),
            .rem_out    (rem_w[k+1])
        );
    end

    assign done = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobed while scan still running");

    a_chain_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        flags_w[MAX_HOLES].valid |-> (state_reg == ST_SCAN))
        else $error("candidate left the chain outside a scan");

    a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> (state_reg == ST_SCAN) && !flags_w[MAX_HOLES].valid)
        else $error("launch without a fresh scan");
`endif

endmodule
